// ----- rtl/core/uart_rb_pkg.sv -----
package uart_rb_pkg;

  localparam int unsigned DefaultDepth = 32;
  localparam int unsigned RecvLevelW   = 6;

  typedef enum logic [1:0] {
    FUNC_HOST_WRITE = 2'd0,
    FUNC_HOST_READ  = 2'd1,
    FUNC_LINE_RX    = 2'd2,
    FUNC_TX_READY   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TX_FULL  = 2'd1,
    ST_RX_EMPTY = 2'd2,
    ST_RX_DROP  = 2'd3
  } status_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_e               status;
    logic [7:0]            read_byte;
    logic                  send_valid;
    logic [7:0]            send_byte;
    logic [RecvLevelW-1:0] receive_level;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/core/uart_tx_rx_ring_buffers_top.sv -----
// Buffered serial-port front end: a transmit ring FIFO and a receive ring
// FIFO of DEPTH bytes each, driven by one event channel.
// Input channel (in_valid_i / in_stall_o / in_data_i): one event per
// transfer - host write, host read, byte received from the line, or
// transmitter ready. Output channel (out_valid_o / out_stall_i /
// out_data_o): exactly one result per event, in event order.
// Each event is captured, then applied to the FIFOs with a registered
// memory read, then loaded into the output register once it is free.
// The controller steps one event at a time through the FIFO memories,
// each read through its registered port.
// The output register holds a finished result while the next event is
// taken in. If the receiver stalls, that result holds and the following
// one waits in the datapath; the input then stalls until it can move on.
// Reset empties both FIFOs, marks the transmitter idle and clears the
// output valid; FIFO memory contents are not cleared and need no pass.
module uart_tx_rx_ring_buffers_top #(
  parameter int unsigned DEPTH = uart_rb_pkg::DefaultDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  uart_rb_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output uart_rb_pkg::out_item_t out_data_o
);
  import uart_rb_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  uart_rb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  uart_rb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ----- rtl/core/uart_rb_ctrl.sv -----
module uart_rb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  uart_rb_pkg::dp_stat_t stat_i,
  output uart_rb_pkg::ctl_cmd_t cmd_o
);
  import uart_rb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register is free
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/uart_rb_dp.sv -----
module uart_rb_dp #(
  parameter int unsigned DEPTH = uart_rb_pkg::DefaultDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  uart_rb_pkg::in_item_t  in_data_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output uart_rb_pkg::out_item_t out_data_o,
  input  uart_rb_pkg::ctl_cmd_t  cmd_i,
  output uart_rb_pkg::dp_stat_t  stat_o
);
  import uart_rb_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx  = AW'(DEPTH - 1);
  localparam logic [LW-1:0] TxLimit  = LW'(DEPTH - 1);
  localparam logic [LW-1:0] RxLimit  = LW'(DEPTH);

  logic [7:0] tx_mem [DEPTH];
  logic [7:0] rx_mem [DEPTH];

  in_item_t        item_q;
  logic [AW-1:0]   tx_head_q, tx_tail_q, rx_head_q, rx_tail_q;
  logic [LW-1:0]   tx_level_q, rx_level_q;
  logic            tx_idle_q;
  logic [7:0]      tx_rd_q, rx_rd_q;

  // result of the executed transfer, waiting for the memory read data
  status_e         pend_status_q;
  logic            pend_rd_q;
  logic            pend_sv_q;
  logic            pend_from_mem_q;

  out_item_t       out_q;
  logic            out_valid_q;

  logic            tx_push, tx_pop, rx_push, rx_pop, bypass, go_idle;
  status_e         status_d;

  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + AW'(1);
  endfunction

  always_comb begin
    tx_push  = 1'b0;
    tx_pop   = 1'b0;
    rx_push  = 1'b0;
    rx_pop   = 1'b0;
    bypass   = 1'b0;
    go_idle  = 1'b0;
    status_d = ST_OK;
    case (item_q.func)
      FUNC_HOST_WRITE: begin
        if (tx_idle_q && tx_level_q == '0) begin
          bypass = 1'b1;
        end else if (tx_level_q >= TxLimit) begin
          status_d = ST_TX_FULL;
        end else begin
          tx_push = 1'b1;
        end
      end
      FUNC_HOST_READ: begin
        if (rx_level_q == '0) begin
          status_d = ST_RX_EMPTY;
        end else begin
          rx_pop = 1'b1;
        end
      end
      FUNC_LINE_RX: begin
        if (rx_level_q >= RxLimit) begin
          status_d = ST_RX_DROP;
        end else begin
          rx_push = 1'b1;
        end
      end
      default: begin
        if (tx_level_q != '0) begin
          tx_pop = 1'b1;
        end else begin
          go_idle = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (tx_push) begin
        tx_mem[tx_tail_q] <= item_q.data_byte;
      end
      tx_rd_q <= tx_mem[tx_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (rx_push) begin
        rx_mem[rx_tail_q] <= item_q.data_byte;
      end
      rx_rd_q <= rx_mem[rx_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      pend_status_q   <= status_d;
      pend_rd_q       <= rx_pop;
      pend_sv_q       <= bypass | tx_pop;
      pend_from_mem_q <= tx_pop;
    end
    if (cmd_i.load) begin
      out_q.status        <= pend_status_q;
      out_q.read_byte     <= pend_rd_q ? rx_rd_q : 8'd0;
      out_q.send_valid    <= pend_sv_q;
      out_q.send_byte     <= !pend_sv_q ? 8'd0 :
                             (pend_from_mem_q ? tx_rd_q : item_q.data_byte);
      out_q.receive_level <= RecvLevelW'(rx_level_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      tx_level_q  <= '0;
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      rx_level_q  <= '0;
      tx_idle_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        if (tx_push) begin
          tx_tail_q  <= wrap_next(tx_tail_q);
          tx_level_q <= tx_level_q + LW'(1);
        end
        if (tx_pop) begin
          tx_head_q  <= wrap_next(tx_head_q);
          tx_level_q <= tx_level_q - LW'(1);
        end
        if (rx_push) begin
          rx_tail_q  <= wrap_next(rx_tail_q);
          rx_level_q <= rx_level_q + LW'(1);
        end
        if (rx_pop) begin
          rx_head_q  <= wrap_next(rx_head_q);
          rx_level_q <= rx_level_q - LW'(1);
        end
        if (bypass || tx_pop) begin
          tx_idle_q <= 1'b0;
        end else if (go_idle) begin
          tx_idle_q <= 1'b1;
        end
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

// ----- tb/sv/uart_rb_fifo_check.sv -----
module uart_rb_fifo_check
  import uart_rb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        due_count_o,
  output int        mismatch_count_o
);

  localparam int Depth = DefaultDepth;

  logic [7:0] tx_mem [Depth];
  logic [7:0] rx_mem [Depth];
  int         tx_rd, tx_wr, tx_cnt;
  int         rx_rd, rx_wr, rx_cnt;
  bit         tx_idle;

  out_item_t  results_due [$];
  int         result_idx;

  function automatic int ring_next(int idx);
    return (idx == Depth - 1) ? 0 : idx + 1;
  endfunction

  // Apply one event to the FIFO state and return the result it produces.
  function automatic out_item_t serve_event(in_item_t ev);
    out_item_t r;
    r = '0;
    r.status = ST_OK;
    case (ev.func)
      FUNC_HOST_WRITE: begin
        if (tx_idle && tx_cnt == 0) begin
          r.send_valid = 1'b1;
          r.send_byte  = ev.data_byte;
          tx_idle      = 1'b0;
        end else if (tx_cnt >= Depth - 1) begin
          r.status = ST_TX_FULL;
        end else begin
          tx_mem[tx_wr] = ev.data_byte;
          tx_wr         = ring_next(tx_wr);
          tx_cnt++;
        end
      end
      FUNC_HOST_READ: begin
        if (rx_cnt == 0) begin
          r.status = ST_RX_EMPTY;
        end else begin
          r.read_byte = rx_mem[rx_rd];
          rx_rd       = ring_next(rx_rd);
          rx_cnt--;
        end
      end
      FUNC_LINE_RX: begin
        if (rx_cnt >= Depth) begin
          r.status = ST_RX_DROP;
        end else begin
          rx_mem[rx_wr] = ev.data_byte;
          rx_wr         = ring_next(rx_wr);
          rx_cnt++;
        end
      end
      default: begin
        if (tx_cnt != 0) begin
          r.send_valid = 1'b1;
          r.send_byte  = tx_mem[tx_rd];
          tx_rd        = ring_next(tx_rd);
          tx_cnt--;
          tx_idle      = 1'b0;
        end else begin
          tx_idle = 1'b1;
        end
      end
    endcase
    r.receive_level = rx_cnt[RecvLevelW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("result %0d: %s mismatch, got %0d, want %0d", result_idx, what, got, want);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      tx_rd   = 0;
      tx_wr   = 0;
      tx_cnt  = 0;
      rx_rd   = 0;
      rx_wr   = 0;
      rx_cnt  = 0;
      tx_idle = 1'b1;
      results_due.delete();
      result_idx       = 0;
      mismatch_count_o = 0;
      due_count_o     <= 0;
    end else begin
      // compare before predicting: a result always belongs to an earlier transfer
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing due, status", out_data_i.status, 0);
        end else begin
          want = results_due.pop_front();
          if (out_data_i.status !== want.status)
            report_mismatch("status", out_data_i.status, want.status);
          if (out_data_i.read_byte !== want.read_byte)
            report_mismatch("read_byte", out_data_i.read_byte, want.read_byte);
          if (out_data_i.send_valid !== want.send_valid)
            report_mismatch("send_valid", out_data_i.send_valid, want.send_valid);
          if (out_data_i.send_byte !== want.send_byte)
            report_mismatch("send_byte", out_data_i.send_byte, want.send_byte);
          if (out_data_i.receive_level !== want.receive_level)
            report_mismatch("receive_level", out_data_i.receive_level,
                            want.receive_level);
        end
        result_idx++;
      end
      if (in_valid_i && !in_stall_i)
        results_due.push_back(serve_event(in_data_i));
      due_count_o <= results_due.size();
    end
  end

endmodule

// ----- tb/sv/tb_uart_tx_rx_ring_buffers_top.sv -----
module tb_uart_tx_rx_ring_buffers_top;
  import uart_rb_pkg::*;

  localparam int TotalItems = 450;
  localparam int LongHold   = 60;
  localparam int IdleLimit  = 2000;
  localparam int FillRx     = 36;
  localparam int FillTx     = 34;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  int due_count;
  int mismatch_count;
  int items_sent;
  bit sender_gaps;
  bit hold_req;
  bit holding;

  uart_tx_rx_ring_buffers_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  uart_rb_fifo_check u_fifo_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_i       (out_data_o),
    .due_count_o      (due_count),
    .mismatch_count_o (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // Bias each burst toward filling or draining one of the FIFOs, or, for any other kind, pick every function at random.
  function automatic func_e pick_func(int kind);
    func_e main_fn;
    func_e side_fn;
    int    r;
    case (kind)
      0:       begin main_fn = FUNC_HOST_WRITE; side_fn = FUNC_TX_READY;   end
      1:       begin main_fn = FUNC_TX_READY;   side_fn = FUNC_HOST_WRITE; end
      2:       begin main_fn = FUNC_LINE_RX;    side_fn = FUNC_HOST_READ;  end
      3:       begin main_fn = FUNC_HOST_READ;  side_fn = FUNC_LINE_RX;    end
      default: return func_e'($urandom_range(0, 3));
    endcase
    r = $urandom_range(0, 99);
    if (r < 70) return main_fn;
    if (r < 90) return side_fn;
    return func_e'($urandom_range(0, 3));
  endfunction

  // Offer one event and hold it until the transfer; returns at a falling edge.
  task automatic send_event(input func_e fn, input logic [7:0] data);
    in_item_t ev;
    int       gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    ev.func      = fn;
    ev.data_byte = data;
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (due_count != 0) @(negedge clk_i);
  endtask

  // Receiver: random stall runs, plus one long hold on request.
  initial begin
    int stall_len;
    int ready_len;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        holding = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
        hold_req = 1'b0;
        holding  = 1'b0;
      end else begin
        stall_len = pick_gap();
        ready_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 20);
        if (stall_len > 0) begin
          out_stall_i <= 1'b1;
          repeat (stall_len) @(negedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat (ready_len) @(negedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    @(posedge rst_ni);
    while (idle_run < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("uart_tx_rx_ring_buffers_top test failed");
    $finish;
  end

  initial begin
    int kind;
    int burst;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    items_sent  = 0;
    sender_gaps = 1'b1;
    hold_req    = 1'b0;
    holding     = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: idle/busy transmitter, bypass, queueing, empty read, extremes
    send_event(FUNC_TX_READY,   8'h00);
    send_event(FUNC_HOST_READ,  8'hff);
    send_event(FUNC_HOST_WRITE, 8'h00);
    send_event(FUNC_HOST_WRITE, 8'hff);
    send_event(FUNC_HOST_WRITE, 8'h80);
    send_event(FUNC_TX_READY,   8'h55);
    send_event(FUNC_TX_READY,   8'haa);
    send_event(FUNC_TX_READY,   8'h00);
    send_event(FUNC_TX_READY,   8'hff);
    send_event(FUNC_LINE_RX,    8'h00);
    send_event(FUNC_LINE_RX,    8'hff);
    send_event(FUNC_LINE_RX,    8'h5a);
    send_event(FUNC_HOST_READ,  8'h00);
    send_event(FUNC_HOST_READ,  8'h01);
    send_event(FUNC_HOST_READ,  8'hfe);
    send_event(FUNC_HOST_READ,  8'h7f);
    send_event(FUNC_HOST_WRITE, 8'ha5);
    send_event(FUNC_TX_READY,   8'h00);
    send_event(FUNC_TX_READY,   8'h00);
    wait_drained();

    // long receiver hold while the line overfills the receive FIFO and
    // the host overfills the transmit FIFO
    hold_req = 1'b1;
    wait (holding);
    sender_gaps = 1'b0;
    for (int i = 0; i < FillRx; i++) send_event(FUNC_LINE_RX, pick_byte());
    for (int i = 0; i < FillTx; i++) send_event(FUNC_HOST_WRITE, pick_byte());
    wait_drained();

    while (items_sent < TotalItems) begin
      kind        = $urandom_range(0, 4);
      burst       = $urandom_range(4, 60);
      sender_gaps = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < burst; i++) send_event(pick_func(kind), pick_byte());
    end
    wait_drained();
    repeat (8) @(negedge clk_i);

    if (mismatch_count == 0)
      $display("uart_tx_rx_ring_buffers_top test passed");
    else
      $display("uart_tx_rx_ring_buffers_top test failed");
    $finish;
  end

endmodule
